### design/near_duplicate_coord_merge_top_assert.svh
// Assertion macros for the coordinate merge block.
// Both macros sample on clock and are disabled while reset is high.
`ifndef NEAR_DUPLICATE_COORD_MERGE_TOP_ASSERT_SVH
`define NEAR_DUPLICATE_COORD_MERGE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define NDCM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define NDCM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define NDCM_ASSERT_SAME(lbl, ante, cons, msg)
`define NDCM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/ndcm_pkg.sv
`timescale 1ns / 1ps
package ndcm_pkg;

   localparam int NDCM_MAX_ENTRIES = 64;
   localparam int ENTRY_W          = 6;
   localparam int COORD_W          = 32;
   localparam int COUNT_W          = 16;
   localparam int TOL_W            = 16;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

   typedef struct packed {
      logic signed [COORD_W-1:0] u_coord;
      logic signed [COORD_W-1:0] v_coord;
      logic [COUNT_W-1:0]        use_count;
      logic                      last_entry;
   } req_word_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] entry_number;
      logic               still_live;
      logic               has_alias;
      logic [ENTRY_W-1:0] alias_number;
      logic [COUNT_W-1:0] merged_count;
      logic               overflow_seen;
      logic               last_result;
   } rsp_word_type;

   // Memory port controls from the sequencer; addresses sized for the largest table.
   typedef struct packed {
      logic               rd_en;
      logic [ENTRY_W-1:0] rd_addr;
      logic               uv_wr_en;
      logic               cnt_wr_en;
      logic [ENTRY_W-1:0] cnt_addr;
      logic [COUNT_W-1:0] cnt_data;
      logic               alias_wr_en;
      logic [ENTRY_W-1:0] alias_addr;
      logic               alias_flag;
      logic [ENTRY_W-1:0] alias_index;
   } mem_ctl_type;

   // Exact difference at 34 bits, strict bound on both sides.
   function automatic logic axis_close(input logic signed [COORD_W-1:0] a,
                                       input logic signed [COORD_W-1:0] b,
                                       input logic [TOL_W-1:0] tol);
      logic signed [COORD_W+1:0] d;
      logic signed [COORD_W+1:0] t;
      d = (COORD_W+2)'(a) - (COORD_W+2)'(b);
      t = $signed((COORD_W+2)'(tol));
      return (d < t) && (d > -t);
   endfunction

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
   endfunction

endpackage

### design/ndcm_ram.sv
`timescale 1ns / 1ps
module ndcm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

### design/ndcm_seq.sv
`timescale 1ns / 1ps
module ndcm_seq import ndcm_pkg::*; #(
   parameter int MAX_ENTRIES = NDCM_MAX_ENTRIES,
   localparam int IDX_W = $clog2(MAX_ENTRIES),
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_word_type              req_word,
   input  logic [TOL_W-1:0]          tol,
   input  logic signed [COORD_W-1:0] u_rd,
   input  logic signed [COORD_W-1:0] v_rd,
   input  logic [COUNT_W-1:0]        cnt_rd,
   input  logic [IDX_W:0]            alias_rd,
   output mem_ctl_type               mem_ctl,
   output logic                      rsp_strobe,
   output rsp_word_type              rsp_word
);

   typedef enum logic [2:0] {
      ST_LOAD, ST_I_RD, ST_I_CAP, ST_J_RD, ST_J_CMP, ST_J_MRG, ST_I_END, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      drain_ff, drain_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic             ovf_ff, ovf_in;
   logic signed [COORD_W-1:0] ui_ff, ui_in;
   logic signed [COORD_W-1:0] vi_ff, vi_in;
   logic [COUNT_W-1:0]        cnti_ff, cnti_in;
   logic                      match_ff, match_in;
   logic                      out_pend_ff, out_pend_in;
   logic [IDX_W-1:0]          out_k_ff, out_k_in;

   logic [IDX_W-1:0] i_idx, j_idx, fill_idx;

   assign i_idx    = i_ff[IDX_W-1:0];
   assign j_idx    = j_ff[IDX_W-1:0];
   assign fill_idx = fill_ff[IDX_W-1:0];

   // An entry is live while its alias flag is clear; the flag is read with the entry.
   always_comb begin
      state_in    = state_ff;
      drain_in    = 1'b0;
      fill_in     = fill_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      ovf_in      = ovf_ff;
      ui_in       = ui_ff;
      vi_in       = vi_ff;
      cnti_in     = cnti_ff;
      match_in    = match_ff;
      out_pend_in = 1'b0;
      out_k_in    = out_k_ff;
      mem_ctl     = '0;

      // The last result goes out in the cycle after the final read; the table clears then.
      if (drain_ff) begin
         fill_in  = '0;
         ovf_in   = 1'b0;
         state_in = ST_LOAD;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (start) begin
                  if (fill_ff < CNT_W'(MAX_ENTRIES)) begin
                     mem_ctl.uv_wr_en    = 1'b1;
                     mem_ctl.cnt_wr_en   = 1'b1;
                     mem_ctl.cnt_addr    = ENTRY_W'(fill_idx);
                     mem_ctl.cnt_data    = req_word.use_count;
                     mem_ctl.alias_wr_en = 1'b1;
                     mem_ctl.alias_addr  = ENTRY_W'(fill_idx);
                     fill_in             = fill_ff + CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_word.last_entry) begin
                     i_in     = '0;
                     state_in = ST_I_RD;
                  end
               end
            end
            ST_I_RD: begin
               if (i_ff >= fill_ff) begin
                  j_in     = '0;
                  state_in = ST_OUT;
               end else begin
                  mem_ctl.rd_en   = 1'b1;
                  mem_ctl.rd_addr = ENTRY_W'(i_idx);
                  state_in        = ST_I_CAP;
               end
            end
            ST_I_CAP: begin
               if (alias_rd[IDX_W]) begin
                  // merged away earlier: no scan, and its count stays as stored
                  i_in     = i_ff + CNT_W'(1);
                  state_in = ST_I_RD;
               end else begin
                  ui_in    = u_rd;
                  vi_in    = v_rd;
                  cnti_in  = cnt_rd;
                  j_in     = i_ff + CNT_W'(1);
                  state_in = ST_J_RD;
               end
            end
            ST_J_RD: begin
               if (j_ff >= fill_ff) begin
                  state_in = ST_I_END;
               end else begin
                  mem_ctl.rd_en   = 1'b1;
                  mem_ctl.rd_addr = ENTRY_W'(j_idx);
                  state_in        = ST_J_CMP;
               end
            end
            ST_J_CMP: begin
               if (alias_rd[IDX_W]) begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = ST_J_RD;
               end else begin
                  match_in = axis_close(ui_ff, u_rd, tol) && axis_close(vi_ff, v_rd, tol);
                  state_in = ST_J_MRG;
               end
            end
            ST_J_MRG: begin
               if (!match_ff) begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = ST_J_RD;
               end else if (cnti_ff > cnt_rd) begin
                  // j folds into i; i's count stays in a register until its scan ends
                  cnti_in             = sat_add(cnti_ff, cnt_rd);
                  mem_ctl.alias_wr_en = 1'b1;
                  mem_ctl.alias_addr  = ENTRY_W'(j_idx);
                  mem_ctl.alias_flag  = 1'b1;
                  mem_ctl.alias_index = ENTRY_W'(i_idx);
                  j_in                = j_ff + CNT_W'(1);
                  state_in            = ST_J_RD;
               end else begin
                  mem_ctl.alias_wr_en = 1'b1;
                  mem_ctl.alias_addr  = ENTRY_W'(i_idx);
                  mem_ctl.alias_flag  = 1'b1;
                  mem_ctl.alias_index = ENTRY_W'(j_idx);
                  mem_ctl.cnt_wr_en   = 1'b1;
                  mem_ctl.cnt_addr    = ENTRY_W'(j_idx);
                  mem_ctl.cnt_data    = sat_add(cnt_rd, cnti_ff);
                  state_in            = ST_I_END;
               end
            end
            ST_I_END: begin
               mem_ctl.cnt_wr_en = 1'b1;
               mem_ctl.cnt_addr  = ENTRY_W'(i_idx);
               mem_ctl.cnt_data  = cnti_ff;
               i_in              = i_ff + CNT_W'(1);
               state_in          = ST_I_RD;
            end
            ST_OUT: begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = ENTRY_W'(j_idx);
               out_pend_in     = 1'b1;
               out_k_in        = j_idx;
               j_in            = j_ff + CNT_W'(1);
               if (j_ff + CNT_W'(1) >= fill_ff) begin
                  drain_in = 1'b1;
               end
            end
            default: begin
               state_in = ST_LOAD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      ui_ff    <= ui_in;
      vi_ff    <= vi_in;
      cnti_ff  <= cnti_in;
      match_ff <= match_in;
      out_k_ff <= out_k_in;
      if (reset) begin
         state_ff    <= ST_LOAD;
         drain_ff    <= 1'b0;
         fill_ff     <= '0;
         ovf_ff      <= 1'b0;
         out_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         drain_ff    <= drain_in;
         fill_ff     <= fill_in;
         ovf_ff      <= ovf_in;
         out_pend_ff <= out_pend_in;
      end
   end

   assign busy       = (state_ff != ST_LOAD);
   assign rsp_strobe = out_pend_ff;

   always_comb begin
      rsp_word.entry_number  = ENTRY_W'(out_k_ff);
      rsp_word.still_live    = !alias_rd[IDX_W];
      rsp_word.has_alias     = alias_rd[IDX_W];
      rsp_word.alias_number  = alias_rd[IDX_W] ? ENTRY_W'(alias_rd[IDX_W-1:0]) : '0;
      rsp_word.merged_count  = cnt_rd;
      rsp_word.overflow_seen = ovf_ff;
      rsp_word.last_result   = (CNT_W'(out_k_ff) + CNT_W'(1) == fill_ff);
   end

endmodule

### design/near_duplicate_coord_merge_top.sv
// Loads: one word per cycle, no result; busy stays low until the word marked last.
// Pass: each live entry i is compared with every later live entry; merged-away entries are
// skipped without a compare, and the scan of i ends as soon as i itself is merged away.
// Results: one per stored entry on consecutive cycles, starting after the pass;
// busy drops the cycle after the last one. The receiver cannot stall.
// Synchronous reset clears fill level, flags and tolerance (back to 7); no clearing pass.
`timescale 1ns / 1ps
`include "near_duplicate_coord_merge_top_assert.svh"
module near_duplicate_coord_merge_top import ndcm_pkg::*; #(
   parameter int MAX_ENTRIES = NDCM_MAX_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_word_type     req_word,
   output logic             rsp_strobe,
   output rsp_word_type     rsp_word,
   input  logic             csr_we,
   input  logic [TOL_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);

   logic [TOL_W-1:0]          tol_ff;
   mem_ctl_type               mem_ctl;
   logic [COORD_W-1:0]        u_rd, v_rd;
   logic [COUNT_W-1:0]        cnt_rd;
   logic [IDX_W:0]            alias_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   // Sequencer never reads and writes the same entry in one cycle, so no bypass is needed.
   ndcm_ram #(.WIDTH(COORD_W), .DEPTH(MAX_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.uv_wr_en),
      .wr_addr (mem_ctl.cnt_addr[IDX_W-1:0]),
      .wr_data (req_word.u_coord),
      .rd_en   (mem_ctl.rd_en),
      .rd_addr (mem_ctl.rd_addr[IDX_W-1:0]),
      .rd_data (u_rd)
   );

   ndcm_ram #(.WIDTH(COORD_W), .DEPTH(MAX_ENTRIES)) v_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.uv_wr_en),
      .wr_addr (mem_ctl.cnt_addr[IDX_W-1:0]),
      .wr_data (req_word.v_coord),
      .rd_en   (mem_ctl.rd_en),
      .rd_addr (mem_ctl.rd_addr[IDX_W-1:0]),
      .rd_data (v_rd)
   );

   ndcm_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_ENTRIES)) cnt_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.cnt_wr_en),
      .wr_addr (mem_ctl.cnt_addr[IDX_W-1:0]),
      .wr_data (mem_ctl.cnt_data),
      .rd_en   (mem_ctl.rd_en),
      .rd_addr (mem_ctl.rd_addr[IDX_W-1:0]),
      .rd_data (cnt_rd)
   );

   ndcm_ram #(.WIDTH(IDX_W + 1), .DEPTH(MAX_ENTRIES)) alias_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.alias_wr_en),
      .wr_addr (mem_ctl.alias_addr[IDX_W-1:0]),
      .wr_data ({mem_ctl.alias_flag, mem_ctl.alias_index[IDX_W-1:0]}),
      .rd_en   (mem_ctl.rd_en),
      .rd_addr (mem_ctl.rd_addr[IDX_W-1:0]),
      .rd_data (alias_rd)
   );

   ndcm_seq #(.MAX_ENTRIES(MAX_ENTRIES)) seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .tol        (tol_ff),
      .u_rd       ($signed(u_rd)),
      .v_rd       ($signed(v_rd)),
      .cnt_rd     (cnt_rd),
      .alias_rd   (alias_rd),
      .mem_ctl    (mem_ctl),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   `NDCM_ASSERT_SAME(a_rsp_only_busy, rsp_strobe, busy, "result word while idle")
   `NDCM_ASSERT_NEXT(a_last_starts_pass, start && !busy && req_word.last_entry, busy,
                     "final load did not start the pass")
   `NDCM_ASSERT_NEXT(a_nothing_after_last, rsp_strobe && rsp_word.last_result, !rsp_strobe,
                     "result word after the final one")

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import ndcm_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic             clock;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_word_type     req_word = '0;
   logic             rsp_strobe;
   rsp_word_type     rsp_word;
   logic             csr_we = 1'b0;
   logic [TOL_W-1:0] csr_wdata = TOL_RESET;

   near_duplicate_coord_merge_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   req_word_type pending_words[$];
   rsp_word_type expected_results[$];
   int           idle_pct = 10;
   int           error_count = 0;
   int           cycle_count = 0;
   logic         word_taken = 1'b0;

   // predictor copy of the table and tolerance
   logic [TOL_W-1:0]          tol_now = TOL_RESET;
   logic signed [COORD_W-1:0] tbl_u [NDCM_MAX_ENTRIES];
   logic signed [COORD_W-1:0] tbl_v [NDCM_MAX_ENTRIES];
   logic [COUNT_W-1:0]        tbl_count [NDCM_MAX_ENTRIES];
   bit                        tbl_live [NDCM_MAX_ENTRIES];
   bit                        tbl_aliased [NDCM_MAX_ENTRIES];
   logic [ENTRY_W-1:0]        tbl_target [NDCM_MAX_ENTRIES];
   int                        tbl_fill = 0;
   bit                        tbl_dropped = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit coords_near(input logic signed [COORD_W-1:0] a,
                                      input logic signed [COORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return d < longint'(tol_now);
   endfunction

   function automatic logic [COUNT_W-1:0] count_sum(input logic [COUNT_W-1:0] a,
                                                    input logic [COUNT_W-1:0] b);
      int unsigned s;
      s = int'(a) + int'(b);
      return (s > 65535) ? 16'hffff : s[COUNT_W-1:0];
   endfunction

   task automatic merge_and_report();
      rsp_word_type r;
      for (int i = 0; i < tbl_fill; i++) begin
         if (!tbl_live[i]) continue;
         for (int j = i + 1; j < tbl_fill && tbl_live[i]; j++) begin
            if (!tbl_live[j]) continue;
            if (!(coords_near(tbl_u[i], tbl_u[j]) && coords_near(tbl_v[i], tbl_v[j])))
               continue;
            if (tbl_count[i] > tbl_count[j]) begin
               tbl_aliased[j] = 1'b1;
               tbl_target[j]  = i[ENTRY_W-1:0];
               tbl_count[i]   = count_sum(tbl_count[i], tbl_count[j]);
               tbl_live[j]    = 1'b0;
            end else begin
               tbl_aliased[i] = 1'b1;
               tbl_target[i]  = j[ENTRY_W-1:0];
               tbl_count[j]   = count_sum(tbl_count[j], tbl_count[i]);
               tbl_live[i]    = 1'b0;
            end
         end
      end
      for (int k = 0; k < tbl_fill; k++) begin
         r.entry_number  = k[ENTRY_W-1:0];
         r.still_live    = tbl_live[k];
         r.has_alias     = tbl_aliased[k];
         r.alias_number  = tbl_aliased[k] ? tbl_target[k] : '0;
         r.merged_count  = tbl_count[k];
         r.overflow_seen = tbl_dropped;
         r.last_result   = (k == tbl_fill - 1);
         expected_results.push_back(r);
      end
      tbl_fill    = 0;
      tbl_dropped = 1'b0;
   endtask

   task automatic load_entry(input req_word_type w);
      if (tbl_fill < NDCM_MAX_ENTRIES) begin
         tbl_u[tbl_fill]       = w.u_coord;
         tbl_v[tbl_fill]       = w.v_coord;
         tbl_count[tbl_fill]   = w.use_count;
         tbl_live[tbl_fill]    = 1'b1;
         tbl_aliased[tbl_fill] = 1'b0;
         tbl_target[tbl_fill]  = '0;
         tbl_fill++;
      end else begin
         tbl_dropped = 1'b1;
      end
      if (w.last_entry) merge_and_report();
   endtask

   task automatic report_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
         error_count++;
      end
   endtask

   task automatic check_result(input rsp_word_type got);
      rsp_word_type want;
      if (expected_results.size() == 0) begin
         $display("%0t: result word with none expected, got %p", $time, got);
         error_count++;
      end else begin
         want = expected_results.pop_front();
         report_field("entry_number", 32'(want.entry_number), 32'(got.entry_number));
         report_field("still_live", 32'(want.still_live), 32'(got.still_live));
         report_field("has_alias", 32'(want.has_alias), 32'(got.has_alias));
         report_field("alias_number", 32'(want.alias_number), 32'(got.alias_number));
         report_field("merged_count", 32'(want.merged_count), 32'(got.merged_count));
         report_field("overflow_seen", 32'(want.overflow_seen), 32'(got.overflow_seen));
         report_field("last_result", 32'(want.last_result), 32'(got.last_result));
      end
   endtask

   // driver: new word at the falling edge once the previous one is taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!start || word_taken) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
               start    <= 1'b1;
               req_word <= pending_words.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: results first, then the word accepted at this edge
   always @(posedge clock) begin
      if (reset) begin
         word_taken <= 1'b0;
      end else begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            if (rsp_strobe) check_result(rsp_word);
            word_taken <= start && !busy;
            if (start && !busy) load_entry(req_word);
         end
      end
   end

   task automatic push_entry(input logic [31:0] u, input logic [31:0] v,
                             input logic [15:0] cnt, input bit last);
      req_word_type w;
      w.u_coord    = u;
      w.v_coord    = v;
      w.use_count  = cnt;
      w.last_entry = last;
      pending_words.push_back(w);
   endtask

   // mostly a cluster around one point, spread just past the tolerance; some noise
   task automatic queue_table(input int n_entries);
      logic [31:0] base_u;
      logic [31:0] base_v;
      logic [31:0] u;
      logic [31:0] v;
      logic [15:0] cnt;
      int          spread;
      base_u = $urandom;
      base_v = $urandom;
      spread = int'(tol_now) + 2;
      for (int k = 0; k < n_entries; k++) begin
         if ($urandom_range(3) != 0) begin
            u = base_u + ($urandom_range(2 * spread) - spread);
            v = base_v + ($urandom_range(2 * spread) - spread);
         end else begin
            u = $urandom;
            v = $urandom;
         end
         case ($urandom_range(2))
            0: cnt = 16'($urandom_range(15));
            1: cnt = 16'hffff - 16'($urandom_range(3));
            default: cnt = 16'($urandom);
         endcase
         push_entry(u, v, cnt, k == n_entries - 1);
      end
   endtask

   task automatic queue_random_tables(input int item_budget);
      int n;
      while (item_budget > 0) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
         queue_table(n);
         item_budget -= n;
      end
   endtask

   // sender holds off until the block has gone quiet
   task automatic wait_drained();
      while (!(pending_words.size() == 0 && !start && !busy &&
               expected_results.size() == 0))
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TOL_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      tol_now    = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset tolerance of 7: one-under and exactly-at bounds, extremes, ties, chains
      push_entry(32'd0, 32'd0, 16'd5, 1'b0);
      push_entry(32'd6, -32'sd6, 16'd3, 1'b0);
      push_entry(32'd7, 32'd0, 16'd1, 1'b0);
      push_entry(32'h7fffffff, 32'h80000000, 16'hffff, 1'b0);
      push_entry(32'h80000000, 32'h7fffffff, 16'd0, 1'b0);
      push_entry(32'h7ffffffa, 32'h80000003, 16'hffff, 1'b0);
      push_entry(32'd2, 32'd1, 16'd8, 1'b1);

      // zero tolerance: identical entries stay apart
      write_tolerance(16'd0);
      push_entry(32'h12345678, 32'h9abcdef0, 16'd4, 1'b0);
      push_entry(32'h12345678, 32'h9abcdef0, 16'd4, 1'b1);

      write_tolerance(16'hffff);
      push_entry(32'd0, 32'd0, 16'd10, 1'b0);
      push_entry(32'd65534, -32'sd65534, 16'd20, 1'b0);
      push_entry(32'd65535, 32'd0, 16'd1, 1'b0);
      push_entry(-32'sd65535, 32'd0, 16'd2, 1'b1);
      push_entry(32'hdeadbeef, 32'h0badf00d, 16'hffff, 1'b1);

      write_tolerance(16'($urandom_range(1, 300)));
      queue_random_tables(20);
      queue_table(NDCM_MAX_ENTRIES);

      write_tolerance(16'hffff);
      idle_pct = 60;
      queue_random_tables(20);
      queue_table($urandom_range(NDCM_MAX_ENTRIES + 1, NDCM_MAX_ENTRIES + 6));

      write_tolerance(16'd1);
      idle_pct = 0;
      queue_random_tables(20);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### near_duplicate_coord_merge_top.f
+incdir+design
design/ndcm_pkg.sv
design/ndcm_ram.sv
design/ndcm_seq.sv
design/near_duplicate_coord_merge_top.sv
verif/tb_top.sv
